FILE: rtl/core/joint_actuator_limiter_with_lock_top_macros.svh
// assertion helpers for the joint limiter, clocked on clk and quiet in reset
`ifndef JOINT_ACTUATOR_LIMITER_WITH_LOCK_TOP_MACROS_SVH
`define JOINT_ACTUATOR_LIMITER_WITH_LOCK_TOP_MACROS_SVH

// same-cycle implication
`define JAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/jal_pkg.sv
package jal_pkg;

  localparam int JOINTS      = 5;
  localparam int LOCK_JOINTS = 4;

  // register index on the configuration port
  typedef enum logic [0:0] {
    REG_LOCK_ON  = 1'b0,
    REG_LOCK_OFF = 1'b1
  } jal_reg_t;

  // torque constant, Q16
  function automatic logic [22:0] jal_kt(input logic [2:0] j);
    case (j) inside
      3'd0, 3'd1, 3'd2: return 23'd5937562;
      3'd3, 3'd4:       return 23'd3276800;
      default:          return '0;
    endcase
  endfunction

  // reciprocal of the torque constant, Q32
  function automatic logic [26:0] jal_inv_kt(input logic [2:0] j);
    case (j) inside
      3'd0, 3'd1, 3'd2: return 27'd47405820;
      3'd3, 3'd4:       return 27'd85899346;
      default:          return '0;
    endcase
  endfunction

  // static friction current for positive drive, amps
  function automatic logic [5:0] jal_fwd_static(input logic [2:0] j);
    case (j) inside
      3'd0, 3'd1, 3'd2, 3'd4: return 6'd43;
      3'd3:                   return 6'd10;
      default:                return '0;
    endcase
  endfunction

  // static friction current for negative drive, amps
  function automatic logic [5:0] jal_bwd_static(input logic [2:0] j);
    case (j) inside
      3'd0, 3'd1, 3'd2, 3'd4: return 6'd43;
      3'd3:                   return 6'd20;
      default:                return '0;
    endcase
  endfunction

  // current limit, amps
  function automatic logic [9:0] jal_max_cur(input logic [2:0] j);
    case (j) inside
      3'd0:                   return 10'd600;
      3'd1, 3'd2, 3'd3, 3'd4: return 10'd400;
      default:                return '0;
    endcase
  endfunction

  // low position limit, Q20
  function automatic logic signed [23:0] jal_pos_min(input logic [2:0] j);
    case (j) inside
      3'd0:             return 24'sd1048576;
      3'd1, 3'd2, 3'd3: return 24'sd10486;
      3'd4:             return 24'sd419;
      default:          return '0;
    endcase
  endfunction

  // high position limit, Q20
  function automatic logic signed [23:0] jal_pos_max(input logic [2:0] j);
    case (j) inside
      3'd0:       return 24'sd5767168;
      3'd1, 3'd2: return 24'sd3565158;
      3'd3:       return 24'sd5976883;
      3'd4:       return 24'sd14365;
      default:    return '0;
    endcase
  endfunction

endpackage

FILE: rtl/core/joint_actuator_limiter_with_lock_top.sv
// Joint torque limiter with per-robot hysteresis lock. One word per clock is
// accepted and one result word leaves per clock while out_ready is high and
// no clearing pass runs. Stages: input register, torque-constant multiply,
// friction add, current clamp, deadzone, reciprocal multiply, rounding,
// lock-store read, output register. The lock store is a ROBOTS-entry memory
// read and written at most once per cycle; back-to-back words of the same
// robot are forwarded around it. After reset a clearing pass zeroes the lock
// store while in_ready stays low; configuration writes are taken anytime.
`include "joint_actuator_limiter_with_lock_top_macros.svh"

module joint_actuator_limiter_with_lock_top
  import jal_pkg::*;
#(
  parameter int ROBOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         robot_id,
  input  logic [2:0]         joint_index,
  input  logic signed [23:0] commanded_torque,
  input  logic signed [23:0] joint_position,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] safe_torque,
  output logic               lock_flag,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;

  // configuration registers
  logic [22:0] lock_on;
  logic [22:0] lock_off;
  jal_reg_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = jal_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_on  <= 23'd3277;
      lock_off <= 23'd6554;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_LOCK_ON:  lock_on  <= pwdata[22:0];
        REG_LOCK_OFF: lock_off <= pwdata[22:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCK_ON:  prdata = {9'd0, lock_on};
      REG_LOCK_OFF: prdata = {9'd0, lock_off};
      default:      prdata = '0;
    endcase
  end

  // clearing pass over the lock store
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(ROBOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage valid, ready and move
  logic [9:1] v;
  logic [9:1] rdy;
  logic [9:1] mv;

  always_comb begin
    rdy[9] = !v[9] || out_ready;
    for (int i = 8; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    mv[1] = in_valid && in_ready;
    for (int i = 2; i <= 9; i++) begin
      mv[i] = v[i-1] && rdy[i];
    end
  end

  assign in_ready = rdy[1] && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= mv[1];
      end
      for (int i = 2; i <= 9; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // robot index saturation
  logic [31:0]   robot_ext;
  logic [31:0]   robot_sat;
  assign robot_ext = 32'(robot_id);
  assign robot_sat = (robot_ext >= 32'(ROBOTS)) ? 32'(ROBOTS - 1) : robot_ext;

  // stage 1: input register
  logic [AW-1:0]      s1_robot;
  logic [2:0]         s1_joint;
  logic signed [23:0] s1_tq;
  logic signed [23:0] s1_pos;

  always_ff @(posedge clk) begin
    if (mv[1]) begin
      s1_robot <= robot_sat[AW-1:0];
      s1_joint <= joint_index;
      s1_tq    <= commanded_torque;
      s1_pos   <= joint_position;
    end
  end

  // stage 2: magnitude times torque constant, position limit checks
  logic        neg1;
  logic [23:0] abs1;
  logic [46:0] mag1;

  assign neg1 = s1_tq[23];
  assign abs1 = neg1 ? 24'(-s1_tq) : 24'(s1_tq);
  assign mag1 = 47'(abs1) * 47'(jal_kt(s1_joint));

  logic [AW-1:0] s2_robot;
  logic [2:0]    s2_joint;
  logic          s2_neg;
  logic          s2_below;
  logic          s2_above;
  logic [46:0]   s2_mag;

  always_ff @(posedge clk) begin
    if (mv[2]) begin
      s2_robot <= s1_robot;
      s2_joint <= s1_joint;
      s2_neg   <= neg1;
      s2_below <= s1_pos < jal_pos_min(s1_joint);
      s2_above <= s1_pos > jal_pos_max(s1_joint);
      s2_mag   <= mag1;
    end
  end

  // stage 3: static friction added once the current reaches it
  logic [5:0]  sc2;
  logic [37:0] sc2_q32;
  logic [47:0] magc2;

  assign sc2     = s2_neg ? jal_bwd_static(s2_joint) : jal_fwd_static(s2_joint);
  assign sc2_q32 = {sc2, 32'd0};
  assign magc2   = (48'(s2_mag) >= 48'(sc2_q32)) ? 48'(s2_mag) + 48'(sc2_q32)
                                                : 48'(s2_mag);

  logic [AW-1:0] s3_robot;
  logic [2:0]    s3_joint;
  logic          s3_neg;
  logic          s3_blocked;
  logic [47:0]   s3_magc;

  always_ff @(posedge clk) begin
    if (mv[3]) begin
      s3_robot   <= s2_robot;
      s3_joint   <= s2_joint;
      s3_neg     <= s2_neg;
      // past the low limit no negative current, past the high limit no positive
      s3_blocked <= s2_neg ? s2_below : (s2_above && !s2_below);
      s3_magc    <= magc2;
    end
  end

  // stage 4: clamp to the current limit, zero when the drive direction is blocked
  logic [41:0] maxc3;
  logic [41:0] cm3;

  assign maxc3 = {jal_max_cur(s3_joint), 32'd0};
  assign cm3   = s3_blocked ? '0 :
                 (s3_magc > 48'(maxc3)) ? maxc3 : s3_magc[41:0];

  logic [AW-1:0] s4_robot;
  logic [2:0]    s4_joint;
  logic          s4_neg;
  logic [41:0]   s4_cm;

  always_ff @(posedge clk) begin
    if (mv[4]) begin
      s4_robot <= s3_robot;
      s4_joint <= s3_joint;
      s4_neg   <= s3_neg;
      s4_cm    <= cm3;
    end
  end

  // stage 5: remove the friction deadzone, round to Q16, zero for an unknown joint
  logic [5:0]  sc4;
  logic [41:0] sc4_q32;
  logic [41:0] diff4;
  logic        live4;
  logic        jok4;

  assign sc4     = s4_neg ? jal_bwd_static(s4_joint) : jal_fwd_static(s4_joint);
  assign sc4_q32 = {4'd0, sc4, 32'd0};
  assign diff4   = s4_cm - sc4_q32 + 42'd32768;
  assign live4   = s4_cm > sc4_q32;
  assign jok4    = s4_joint < 3'(JOINTS);

  logic [AW-1:0] s5_robot;
  logic [2:0]    s5_joint;
  logic          s5_neg;
  logic [25:0]   s5_d16;

  always_ff @(posedge clk) begin
    if (mv[5]) begin
      s5_robot <= s4_robot;
      s5_joint <= s4_joint;
      s5_neg   <= s4_neg;
      s5_d16   <= (live4 && jok4) ? diff4[41:16] : '0;
    end
  end

  // stage 6: times the reciprocal torque constant
  logic [AW-1:0] s6_robot;
  logic [2:0]    s6_joint;
  logic          s6_neg;
  logic [52:0]   s6_prod;

  always_ff @(posedge clk) begin
    if (mv[6]) begin
      s6_robot <= s5_robot;
      s6_joint <= s5_joint;
      s6_neg   <= s5_neg;
      s6_prod  <= 53'(s5_d16) * 53'(jal_inv_kt(s5_joint));
    end
  end

  // stage 7: round half up after the Q32 shift; the table ranges keep the
  // magnitude well below the 24-bit signed limit
  logic [53:0] rsum6;
  assign rsum6 = 54'(s6_prod) + 54'd2147483648;

  logic [AW-1:0] s7_robot;
  logic [2:0]    s7_joint;
  logic          s7_neg;
  logic [22:0]   s7_omag;

  always_ff @(posedge clk) begin
    if (mv[7]) begin
      s7_robot <= s6_robot;
      s7_joint <= s6_joint;
      s7_neg   <= s6_neg;
      s7_omag  <= 23'(rsum6[53:32]);
    end
  end

  // lock store, read as a word enters stage 8, written as a locking joint's word leaves
  logic [3:0]    lock_mem [ROBOTS];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_data;
  logic [3:0]    lock_new;

  logic [AW-1:0]      s8_robot;
  logic [2:0]         s8_joint;
  logic               s8_lockj;
  logic               s8_jok;
  logic signed [23:0] s8_safe;
  logic [22:0]        s8_eff;
  logic [3:0]         s8_rd;
  logic               s8_byp;
  logic [3:0]         s8_byp_data;

  assign wr_en   = clearing || (mv[9] && s8_lockj);
  assign wr_addr = clearing ? clr_cnt : s8_robot;
  assign wr_data = clearing ? 4'd0 : lock_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lock_mem[wr_addr] <= wr_data;
    end
    if (mv[8]) begin
      s8_rd <= lock_mem[s7_robot];
    end
  end

  // stage 8: signed torque, lock-store data with forwarding
  always_ff @(posedge clk) begin
    if (mv[8]) begin
      s8_robot    <= s7_robot;
      s8_joint    <= s7_joint;
      s8_lockj    <= s7_joint < 3'(LOCK_JOINTS);
      s8_jok      <= s7_joint < 3'(JOINTS);
      s8_safe     <= s7_neg ? -$signed({1'b0, s7_omag}) : $signed({1'b0, s7_omag});
      s8_eff      <= s7_omag;
      // a write at this same edge is not yet visible in the read data
      s8_byp      <= wr_en && (wr_addr == s7_robot);
      s8_byp_data <= wr_data;
    end
  end

  // hysteresis on the torque magnitude
  logic [3:0] lock_old;
  logic       bit_old;
  logic       bit_new;

  always_comb begin
    lock_old = s8_byp ? s8_byp_data : s8_rd;
    bit_old  = lock_old[s8_joint[1:0]];
    if (!bit_old && (s8_eff < lock_on)) begin
      bit_new = 1'b1;
    end else if (bit_old && (s8_eff > lock_off)) begin
      bit_new = 1'b0;
    end else begin
      bit_new = bit_old;
    end
    lock_new = lock_old;
    lock_new[s8_joint[1:0]] = bit_new;
  end

  // stage 9: output register
  logic               s9_jok;
  logic               s9_lockj;
  logic signed [23:0] s9_safe;
  logic               s9_flag;

  always_ff @(posedge clk) begin
    if (mv[9]) begin
      s9_jok   <= s8_jok;
      s9_lockj <= s8_lockj;
      s9_safe  <= s8_safe;
      s9_flag  <= s8_lockj && bit_new;
    end
  end

  assign out_valid   = v[9];
  assign safe_torque = s9_safe;
  assign lock_flag   = s9_flag;

  // checks
  `JAL_ASSERT_NOW(a_clear_empty, clearing, v == '0, "word in flight during lock clear")
  `JAL_ASSERT_NEXT(a_clear_runs, clearing && (clr_cnt != AW'(ROBOTS - 1)), clearing, "lock clear ended early")
  `JAL_ASSERT_NOW(a_bad_joint_zero, out_valid && !s9_jok, (safe_torque == '0) && !lock_flag, "unknown joint gave nonzero result")
  `JAL_ASSERT_NOW(a_nolock_joint, out_valid && !s9_lockj, !lock_flag, "lock flag on a joint without lock")

endmodule
